// ----- src/nmea_rmc_field_parser_core_macros.svh -----
// Assertion macros for the RMC field parser.
// Included by modules that carry concurrent assertions.
`ifndef NMEA_RMC_FIELD_PARSER_CORE_MACROS_SVH
`define NMEA_RMC_FIELD_PARSER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define NRP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define NRP_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define NRP_ASSERT(lbl, clk, rstn, prop, msg)
`define NRP_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif
`endif

// ----- src/nrp_pkg.sv -----
// Package for the RMC field parser: types, constants, tables.
// No dependencies.
package nrp_pkg;
  localparam int MinFracDigits = 5;
  // scaled minutes stay below 100 * 10^MinFracDigits
  localparam int MinW = $clog2(100 * (10 ** MinFracDigits));
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChPoint = 8'h2E;
  localparam logic [7:0] ChNorth = 8'h4E;
  localparam logic [7:0] ChWest  = 8'h57;
  localparam logic [3:0] FTime = 4'd0;
  localparam logic [3:0] FLat = 4'd2;
  localparam logic [3:0] FLatDir = 4'd3;
  localparam logic [3:0] FLon = 4'd4;
  localparam logic [3:0] FLonDir = 4'd5;
  localparam logic [3:0] FDate = 4'd8;
  localparam logic [3:0] NumFields = 4'd9;

  typedef enum logic [1:0] {
    KIND_TIME = 2'd0,
    KIND_DATE = 2'd1,
    KIND_POS  = 2'd2
  } kind_e;

  // back end sequencing: record issue, then the position conversion
  typedef enum logic [1:0] {B_REC, B_MUL, B_DIV, B_POS} bst_e;

  typedef struct packed {
    kind_e       kind;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [9:0]  sub_second;
    logic [6:0]  day;
    logic [6:0]  month;
    logic [11:0] year;
    logic [29:0] latitude;
    logic        lat_south;
    logic [33:0] longitude;
    logic        lon_west;
  } rec_t;

  // Work item from front end to back end.
  typedef struct packed {
    logic            pos_valid;   // position record follows rec, if any
    logic            rec_valid;
    rec_t            rec;
    logic [9:0]      lat_deg;
    logic [MinW-1:0] lat_min;
    logic [9:0]      lon_deg;
    logic [MinW-1:0] lon_min;
    logic            lat_south;
    logic            lon_west;
  } job_t;

  function automatic logic [31:0] pow10(input int n);
    logic [31:0] r;
    r = 32'd1;
    for (int i = 0; i < 8; i++) if (i < n) r = r * 32'd10;
    return r;
  endfunction
endpackage

// ----- src/nrp_if.sv -----
// Valid/ready stream interfaces for the RMC field parser.
// No dependencies.
interface nrp_in_if (input logic clk_i);
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;
  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

interface nrp_out_if (input logic clk_i);
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [6:0]  hour;
  logic [6:0]  minute;
  logic [6:0]  second;
  logic [9:0]  sub_second;
  logic [6:0]  day;
  logic [6:0]  month;
  logic [11:0] year;
  logic [29:0] latitude;
  logic        lat_south;
  logic [33:0] longitude;
  logic        lon_west;
  modport source (output valid, output record_kind, output hour, output minute,
    output second, output sub_second, output day, output month, output year,
    output latitude, output lat_south, output longitude, output lon_west, input ready);
  modport sink (input valid, input record_kind, input hour, input minute,
    input second, input sub_second, input day, input month, input year,
    input latitude, input lat_south, input longitude, input lon_west, output ready);
endinterface

// ----- src/nrp_front.sv -----
// Front end: per-byte field parsing, emits record jobs to the queue.
// Depends on nrp_pkg and the assertion macros.
`include "nmea_rmc_field_parser_core_macros.svh"
module nrp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  output logic          ready_o,
  output logic          job_valid_o,
  output nrp_pkg::job_t job_o,
  input  logic          job_ready_i
);
  import nrp_pkg::*;

  localparam logic [31:0] Scale = pow10(MinFracDigits);
  localparam logic [31:0] MaxMin = 32'd100 * Scale - 32'd1;
  localparam logic [31:0] ConvMul = pow10(7 - MinFracDigits);

  logic [3:0]  fidx_q, fidx_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        over_q, over_d;
  logic [9:0]  deg_q, deg_d;
  logic [6:0]  hh_q, hh_d, mm_q, mm_d, ss_q, ss_d, dd_q, dd_d, mo_q, mo_d, yy_q, yy_d;
  logic [9:0]  sub_q, sub_d;
  logic [MinW-1:0] mins_q, mins_d;
  logic [2:0]  fseen_q, fseen_d;
  logic        pt_q, pt_d, stop_q, stop_d;
  logic [7:0]  first_q, first_d;
  logic        lat_nz_q, lat_nz_d, lon_nz_q, lon_nz_d;
  logic [1:0]  dir_q, dir_d;
  // latitude/longitude conversion is split: degrees and scaled minutes are
  // latched at field close, the multiply and divide finish in the back end.
  logic [9:0]  latdeg_q, latdeg_d, londeg_q, londeg_d;
  logic [MinW-1:0] latmin_q, latmin_d, lonmin_q, lonmin_d;

  logic accept, end_s, close_s;
  logic [3:0] d;
  logic [39:0] mnext;
  job_t job;

  assign ready_o = job_ready_i;
  assign accept = valid_i && ready_o;
  assign d = (byte_i >= 8'h30 && byte_i <= 8'h39) ? 4'(byte_i - 8'h30) : 4'd0;

  function automatic logic [6:0] acc2(input logic [6:0] a, input logic [3:0] x);
    return 7'((a * 7'd10) + 7'(x));
  endfunction

  // weight of fraction digit k: 10^(MinFracDigits-1-k)
  function automatic logic [31:0] frac_weight(input logic [2:0] k);
    logic [31:0] w;
    w = '0;
    for (int i = 0; i < MinFracDigits; i++) begin
      if (k == 3'(i)) w = pow10(MinFracDigits - 1 - i);
    end
    return w;
  endfunction

  always_comb begin
    fidx_d = fidx_q; cnt_d = cnt_q; over_d = over_q; deg_d = deg_q;
    hh_d = hh_q; mm_d = mm_q; ss_d = ss_q; sub_d = sub_q;
    dd_d = dd_q; mo_d = mo_q; yy_d = yy_q;
    mins_d = mins_q; fseen_d = fseen_q; pt_d = pt_q; stop_d = stop_q;
    first_d = first_q; lat_nz_d = lat_nz_q; lon_nz_d = lon_nz_q; dir_d = dir_q;
    latdeg_d = latdeg_q; londeg_d = londeg_q; latmin_d = latmin_q; lonmin_d = lonmin_q;
    job = '0;
    end_s = 1'b0; close_s = 1'b0;
    mnext = '0;
    if (accept) begin
      if (over_q) begin
        if (last_i) begin
          over_d = 1'b0;
        end
      end else begin
        if (cnt_q == 6'd0 && byte_i == ChStar) begin
          end_s = 1'b1;
        end else if (byte_i == ChComma) begin
          close_s = 1'b1;
          if (cnt_q != 6'd0) begin
            unique case (fidx_q)
              FTime: begin
                if (cnt_q >= 6'd10) begin
                  job.rec_valid = 1'b1;
                  job.rec.kind = KIND_TIME;
                  job.rec.hour = hh_q; job.rec.minute = mm_q;
                  job.rec.second = ss_q; job.rec.sub_second = sub_q;
                end
              end
              FLat: begin
                latdeg_d = deg_q; latmin_d = mins_q;
                lat_nz_d = (deg_q != 10'd0) || (32'(mins_q) * ConvMul >= 32'd60);
              end
              FLon: begin
                londeg_d = deg_q; lonmin_d = mins_q;
                lon_nz_d = (deg_q != 10'd0) || (32'(mins_q) * ConvMul >= 32'd60);
              end
              FLatDir: dir_d[0] = (first_q != ChNorth);
              FLonDir: dir_d[1] = (first_q == ChWest);
              FDate: begin
                job.rec_valid = 1'b1;
                job.rec.kind = KIND_DATE;
                job.rec.day = dd_q; job.rec.month = mo_q;
                job.rec.year = 12'(yy_q) + 12'd2000;
              end
              default: ;
            endcase
          end
          fidx_d = fidx_q + 4'd1;
          if (fidx_q + 4'd1 >= NumFields) end_s = 1'b1;
        end else begin
          if (cnt_q == 6'd0) first_d = byte_i;
          unique case (fidx_q)
            FTime: begin
              if (cnt_q < 6'd2) hh_d = acc2(hh_q, d);
              else if (cnt_q < 6'd4) mm_d = acc2(mm_q, d);
              else if (cnt_q < 6'd6) ss_d = acc2(ss_q, d);
              else if (cnt_q >= 6'd7 && cnt_q < 6'd10) sub_d = 10'(sub_q * 10'd10 + 10'(d));
            end
            FLat, FLon: begin
              if (cnt_q < ((fidx_q == FLat) ? 6'd2 : 6'd3)) begin
                deg_d = 10'(deg_q * 10'd10 + 10'(d));
              end else if (!stop_q) begin
                if (byte_i == ChPoint && !pt_q) pt_d = 1'b1;
                else if (byte_i < 8'h30 || byte_i > 8'h39) stop_d = 1'b1;
                else begin
                  if (!pt_q) mnext = 40'(mins_q) * 40'd10 + 40'(d) * 40'(Scale);
                  else if (fseen_q < 3'(MinFracDigits)) begin
                    mnext = 40'(mins_q) + 40'(d) * 40'(frac_weight(fseen_q));
                    fseen_d = fseen_q + 3'd1;
                  end else mnext = 40'(mins_q);
                  mins_d = (mnext > 40'(MaxMin)) ? MinW'(MaxMin) : MinW'(mnext);
                end
              end
            end
            FDate: begin
              if (cnt_q < 6'd2) dd_d = acc2(dd_q, d);
              else if (cnt_q < 6'd4) mo_d = acc2(mo_q, d);
              else if (cnt_q < 6'd6) yy_d = acc2(yy_q, d);
            end
            default: ;
          endcase
          if (cnt_q != 6'd63) cnt_d = cnt_q + 6'd1;
        end
        if (last_i) end_s = 1'b1;
        if (close_s || end_s) begin
          cnt_d = '0; deg_d = '0; hh_d = '0; mm_d = '0; ss_d = '0; sub_d = '0;
          dd_d = '0; mo_d = '0; yy_d = '0; mins_d = '0; fseen_d = '0;
          pt_d = 1'b0; stop_d = 1'b0; first_d = '0;
        end
        if (end_s) begin
          job.pos_valid = lat_nz_d && lon_nz_d;
          job.lat_deg = latdeg_d; job.lat_min = latmin_d;
          job.lon_deg = londeg_d; job.lon_min = lonmin_d;
          job.lat_south = dir_d[0];
          job.lon_west = dir_d[1];
          fidx_d = '0; lat_nz_d = 1'b0; lon_nz_d = 1'b0; dir_d = '0;
          over_d = !last_i;
        end
      end
    end
  end

  assign job_o = job;
  assign job_valid_o = accept && (job.rec_valid || job.pos_valid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fidx_q <= '0; cnt_q <= '0; over_q <= 1'b0; deg_q <= '0;
      hh_q <= '0; mm_q <= '0; ss_q <= '0; sub_q <= '0;
      dd_q <= '0; mo_q <= '0; yy_q <= '0; mins_q <= '0; fseen_q <= '0;
      pt_q <= 1'b0; stop_q <= 1'b0; first_q <= '0;
      lat_nz_q <= 1'b0; lon_nz_q <= 1'b0; dir_q <= '0;
      latdeg_q <= '0; londeg_q <= '0; latmin_q <= '0; lonmin_q <= '0;
    end else begin
      fidx_q <= fidx_d; cnt_q <= cnt_d; over_q <= over_d; deg_q <= deg_d;
      hh_q <= hh_d; mm_q <= mm_d; ss_q <= ss_d; sub_q <= sub_d;
      dd_q <= dd_d; mo_q <= mo_d; yy_q <= yy_d; mins_q <= mins_d; fseen_q <= fseen_d;
      pt_q <= pt_d; stop_q <= stop_d; first_q <= first_d;
      lat_nz_q <= lat_nz_d; lon_nz_q <= lon_nz_d; dir_q <= dir_d;
      latdeg_q <= latdeg_d; londeg_q <= londeg_d; latmin_q <= latmin_d; lonmin_q <= lonmin_d;
    end
  end

  `NRP_ASSERT(a_cnt_zero_field0, clk_i, rst_ni, !(over_q && cnt_q != 6'd0), "count live after end")
  `NRP_ASSERT(a_fidx_range, clk_i, rst_ni, fidx_q < NumFields, "field index out of range")
  `NRP_ASSERT_NEXT(a_over_clear, clk_i, rst_ni, accept && over_q && last_i, !over_q, "end not cleared")
endmodule

// ----- src/nrp_queue.sv -----
// Short FIFO between front and back ends, 2 entries of job_t.
// Depends on nrp_pkg.
module nrp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  nrp_pkg::job_t data_i,
  output logic          ready_o,
  output logic          valid_o,
  output nrp_pkg::job_t data_o,
  input  logic          pop_i
);
  import nrp_pkg::*;
  job_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic do_push, do_pop;
  assign ready_o = cnt_q != 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o = mem_q[rp_q];
  assign do_push = push_i && ready_o;
  assign do_pop = pop_i && valid_o;
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= data_i;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= !wp_q;
      if (do_pop) rp_q <= !rp_q;
      cnt_q <= 2'(cnt_q + 2'(do_push) - 2'(do_pop));
    end
  end
endmodule

// ----- src/nrp_back.sv -----
// Back end: expands jobs into records, computes position, drives output.
// Depends on nrp_pkg and the assertion macros.
`include "nmea_rmc_field_parser_core_macros.svh"
module nrp_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  nrp_pkg::job_t job_i,
  output logic          job_pop_o,
  output logic          out_valid_o,
  output nrp_pkg::rec_t out_o,
  input  logic          out_ready_i
);
  import nrp_pkg::*;
  localparam logic [31:0] ConvMul = pow10(7 - MinFracDigits);
  // x / 60 == (x * Recip60) >> 36 for every x below 2^30
  localparam logic [30:0] Recip60 = 31'd1145324613;

  // phase 0: issue rec (if any), then for a position job scale, divide by 60, add and emit.
  bst_e st_q, st_d;
  logic        ov_q, ov_d;
  rec_t        ob_q, ob_d;
  logic [29:0] latm_q, lonm_q;
  logic [23:0] latf_q, lonf_q;
  logic [60:0] lat_prod, lon_prod;
  logic        free;
  logic [34:0] lat_sum, lon_sum;

  assign free = !ov_q || out_ready_i;
  assign out_valid_o = ov_q;
  assign out_o = ob_q;
  assign lat_prod = 61'(latm_q) * 61'(Recip60);
  assign lon_prod = 61'(lonm_q) * 61'(Recip60);
  assign lat_sum = 35'(job_i.lat_deg) * 35'd10000000 + 35'(latf_q);
  assign lon_sum = 35'(job_i.lon_deg) * 35'd10000000 + 35'(lonf_q);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      B_REC: if (job_valid_i && free) begin
        if (job_i.pos_valid) st_d = B_MUL;
      end
      B_MUL: st_d = B_DIV;
      B_DIV: st_d = B_POS;
      B_POS: if (free) st_d = B_REC;
      default: st_d = B_REC;
    endcase
  end

  always_comb begin
    job_pop_o = 1'b0;
    ov_d = ov_q;
    ob_d = ob_q;
    if (free) ov_d = 1'b0;
    unique case (st_q)
      B_REC: if (job_valid_i && free) begin
        if (!job_i.pos_valid) job_pop_o = 1'b1;
        if (job_i.rec_valid) begin
          ov_d = 1'b1;
          ob_d = job_i.rec;
        end
      end
      B_POS: if (free) begin
        job_pop_o = 1'b1;
        ov_d = 1'b1;
        ob_d = '0;
        ob_d.kind = KIND_POS;
        ob_d.latitude = lat_sum[29:0];
        ob_d.lat_south = job_i.lat_south;
        ob_d.longitude = lon_sum[33:0];
        ob_d.lon_west = job_i.lon_west;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == B_MUL) begin
      latm_q <= 30'(32'(job_i.lat_min) * ConvMul);
      lonm_q <= 30'(32'(job_i.lon_min) * ConvMul);
    end
    if (st_q == B_DIV) begin
      latf_q <= lat_prod[59:36];
      lonf_q <= lon_prod[59:36];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= B_REC; ov_q <= 1'b0; ob_q <= '0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
      ob_q <= ob_d;
    end
  end

  `NRP_ASSERT_NEXT(a_hold, clk_i, rst_ni, ov_q && !out_ready_i, ov_q && $stable(ob_q), "output dropped")
  `NRP_ASSERT(a_pop_valid, clk_i, rst_ni, !job_pop_o || job_valid_i, "pop of empty queue")
  `NRP_ASSERT_NEXT(a_mul_div, clk_i, rst_ni, st_q == B_MUL, st_q == B_DIV, "position sequence broken")
endmodule

// ----- src/nmea_rmc_field_parser_core.sv -----
// RMC sentence field parser, top level.
// Channels: input bytes (in_byte, last_byte) on a valid/ready sink; records
// (time, date, position) on a valid/ready source.
// Each accepted byte is parsed in the front end; bytes that yield a time,
// date or position record push a job into a two-entry queue.
// Back end: a time or date record passes from the queue head into the output
// register; a position record then steps through B_MUL, B_DIV and B_POS for
// the conversion (minutes scaling, reciprocal multiply for the divide by 60, degree add).
// Throughput: one byte per cycle while the queue has room; the queue
// drains at one time/date job per cycle while the output is free, and holds a position job until B_POS.
// Reset clears all sentence state; no record is pending after reset.
// When the receiver stalls, the output register holds its record, the
// queue fills, and ready drops once it is full.
module nmea_rmc_field_parser_core (
  input logic clk_i,
  input logic rst_ni,
  nrp_in_if.sink   in_if,
  nrp_out_if.source out_if
);
  import nrp_pkg::*;
  logic fv, qr, qv, pop;
  job_t fj, qj;
  rec_t r;

  nrp_front u_front (
    .clk_i, .rst_ni, .valid_i(in_if.valid), .byte_i(in_if.in_byte),
    .last_i(in_if.last_byte), .ready_o(in_if.ready),
    .job_valid_o(fv), .job_o(fj), .job_ready_i(qr)
  );
  nrp_queue u_queue (
    .clk_i, .rst_ni, .push_i(fv), .data_i(fj), .ready_o(qr),
    .valid_o(qv), .data_o(qj), .pop_i(pop)
  );
  nrp_back u_back (
    .clk_i, .rst_ni, .job_valid_i(qv), .job_i(qj), .job_pop_o(pop),
    .out_valid_o(out_if.valid), .out_o(r), .out_ready_i(out_if.ready)
  );
  assign out_if.record_kind = r.kind;
  assign out_if.hour = r.hour;
  assign out_if.minute = r.minute;
  assign out_if.second = r.second;
  assign out_if.sub_second = r.sub_second;
  assign out_if.day = r.day;
  assign out_if.month = r.month;
  assign out_if.year = r.year;
  assign out_if.latitude = r.latitude;
  assign out_if.lat_south = r.lat_south;
  assign out_if.longitude = r.longitude;
  assign out_if.lon_west = r.lon_west;
endmodule

// ----- tb/sv/nmea_rmc_field_parser_core_tb.sv -----
// Self-checking testbench for nmea_rmc_field_parser_core: RMC sentence bytes in,
// time/date/position records out, compared against an in-bench record predictor.
// Depends on nrp_pkg, nrp_if.sv and the parser RTL.
`timescale 1ns / 1ps

module nmea_rmc_field_parser_core_tb;
  import nrp_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam longint unsigned FracScale = 64'd10 ** MinFracDigits;
  localparam longint unsigned MinutesMax = 100 * FracScale - 1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  nrp_in_if  in_if (clk_i);
  nrp_out_if out_if (clk_i);

  nmea_rmc_field_parser_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Shared run state
  rec_t expected_recs[$];
  int   n_errors = 0;
  int   n_beats_in = 0;
  int   n_recs_out = 0;
  int   src_idle_pct = 0;
  int   snk_idle_pct = 0;
  int   hold_request = 0;
  int   hold_left = 0;
  int   idle_cycles = 0;

  // Parser state mirror
  logic [3:0]      fld_idx;
  int              fld_chars;
  bit              sent_over;
  longint unsigned deg_acc, min_scaled, lat_val, lon_val;
  int              frac_seen;
  bit              pt_seen, num_stop;
  int              tm_parts[4];
  int              dt_parts[3];
  logic [7:0]      fld_first;
  bit              dir_south, dir_west;

  function automatic int digit_val(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) ? int'(c - 8'h30) : 0;
  endfunction

  task clear_field();
    fld_chars = 0;
    deg_acc = 0;
    min_scaled = 0;
    frac_seen = 0;
    pt_seen = 0;
    num_stop = 0;
    fld_first = '0;
    foreach (tm_parts[i]) tm_parts[i] = 0;
    foreach (dt_parts[i]) dt_parts[i] = 0;
  endtask

  task clear_sentence();
    clear_field();
    fld_idx = '0;
    lat_val = 0;
    lon_val = 0;
    dir_south = 0;
    dir_west = 0;
  endtask

  task minutes_char(input logic [7:0] c);
    if (num_stop) return;
    if (c == ChPoint && !pt_seen) begin
      pt_seen = 1;
      return;
    end
    if (c < 8'h30 || c > 8'h39) begin
      num_stop = 1;
      return;
    end
    if (!pt_seen) begin
      min_scaled = min_scaled * 10 + digit_val(c) * FracScale;
    end else if (frac_seen < MinFracDigits) begin
      min_scaled += digit_val(c) * (64'd10 ** (MinFracDigits - 1 - frac_seen));
      frac_seen++;
    end
    if (min_scaled > MinutesMax) min_scaled = MinutesMax;
  endtask

  task field_char(input logic [7:0] c);
    int p;
    int d;
    p = fld_chars;
    d = digit_val(c);
    if (p == 0) fld_first = c;
    case (fld_idx)
      FTime: begin
        if (p < 2) tm_parts[0] = tm_parts[0] * 10 + d;
        else if (p < 4) tm_parts[1] = tm_parts[1] * 10 + d;
        else if (p < 6) tm_parts[2] = tm_parts[2] * 10 + d;
        else if (p >= 7 && p < 10) tm_parts[3] = tm_parts[3] * 10 + d;
      end
      FLat, FLon: begin
        if (p < ((fld_idx == FLat) ? 2 : 3)) deg_acc = deg_acc * 10 + d;
        else minutes_char(c);
      end
      FDate: begin
        if (p < 6) dt_parts[p >> 1] = dt_parts[p >> 1] * 10 + d;
      end
      default: ;
    endcase
    if (fld_chars < 63) fld_chars++;
  endtask

  function automatic longint unsigned degrees_e7(input longint unsigned deg,
                                                 input longint unsigned mins);
    return deg * 64'd10_000_000 + mins * (64'd10 ** (7 - MinFracDigits)) / 60;
  endfunction

  task close_field();
    rec_t r;
    r = '0;
    if (fld_chars == 0) return;
    case (fld_idx)
      FTime: begin
        if (fld_chars >= 10) begin
          r.kind = KIND_TIME;
          r.hour = tm_parts[0][6:0];
          r.minute = tm_parts[1][6:0];
          r.second = tm_parts[2][6:0];
          r.sub_second = tm_parts[3][9:0];
          expected_recs.push_back(r);
        end
      end
      FLat:    lat_val = degrees_e7(deg_acc, min_scaled) & 64'h3FFF_FFFF;
      FLon:    lon_val = degrees_e7(deg_acc, min_scaled) & 64'h3_FFFF_FFFF;
      FLatDir: dir_south = (fld_first != ChNorth);
      FLonDir: dir_west = (fld_first == ChWest);
      FDate: begin
        r.kind = KIND_DATE;
        r.day = dt_parts[0][6:0];
        r.month = dt_parts[1][6:0];
        r.year = 12'(dt_parts[2] + 2000);
        expected_recs.push_back(r);
      end
      default: ;
    endcase
  endtask

  // Advance the mirror by one accepted beat, queuing the records it causes.
  task predict_records(input logic [7:0] c, input bit last);
    bit   ended;
    rec_t r;
    if (sent_over) begin
      if (last) begin
        clear_sentence();
        sent_over = 0;
      end
      return;
    end
    ended = 0;
    if (fld_chars == 0 && c == ChStar) begin
      ended = 1;
    end else if (c == ChComma) begin
      close_field();
      clear_field();
      fld_idx++;
      if (fld_idx >= NumFields) ended = 1;
    end else begin
      field_char(c);
    end
    if (last) ended = 1;
    if (ended) begin
      if (lat_val != 0 && lon_val != 0) begin
        r = '0;
        r.kind = KIND_POS;
        r.latitude = lat_val[29:0];
        r.lat_south = dir_south;
        r.longitude = lon_val[33:0];
        r.lon_west = dir_west;
        expected_recs.push_back(r);
      end
      clear_sentence();
      sent_over = !last;
    end
  endtask

  // Send one beat; returns right after the edge that accepted it.
  task send_beat(input logic [7:0] c, input bit last);
    bit acc;
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.in_byte <= c;
    in_if.last_byte <= last;
    do begin
      @(negedge clk_i);
      acc = in_if.ready;
      @(posedge clk_i);
    end while (!acc);
    predict_records(c, last);
    n_beats_in++;
  endtask

  task send_text(input string s, input bit last_on_end);
    for (int i = 0; i < s.len(); i++)
      send_beat(s[i], last_on_end && (i == s.len() - 1));
  endtask

  function automatic string digits(input int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'h30 + 8'($urandom_range(9)))};
    return s;
  endfunction

  // Well-formed sentence with random content, then noise and a random ending.
  function automatic string random_sentence();
    string s;
    string dirs;
    int    cut;
    dirs = "NSWEX";
    s = {digits(6), ".", digits($urandom_range(3, 4)), ",A,",
         digits(4), ".", digits($urandom_range(0, 8)), ",",
         string'(dirs[$urandom_range(4)]), ",",
         digits(5), ".", digits($urandom_range(0, 8)), ",",
         string'(dirs[$urandom_range(4)]), ",",
         digits(3), ".", digits(1), ",", digits(3), ".", digits(1), ",",
         digits(6), ",*", digits(2)};
    if ($urandom_range(9) == 0) s = {s.substr(0, 9), ",", s.substr(11, s.len() - 1)};
    for (int i = 0; i < s.len(); i++)
      if ($urandom_range(99) < 3) s[i] = 8'($urandom_range(255));
    case ($urandom_range(9))
      0, 1: begin
        cut = $urandom_range(1, s.len());
        s = s.substr(0, cut - 1);
      end
      2: s = {s.substr(0, 20), "*", s.substr(21, s.len() - 1)};
      default: ;
    endcase
    return s;
  endfunction

  // Receiver: random stalls plus long requested hold-offs
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task check_field(input string name, input longint unsigned exp_v,
                   input longint unsigned act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      n_errors++;
    end
  endtask

  // Record checker and watchdog, sampled mid-cycle
  always @(negedge clk_i) begin
    rec_t exp_r;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        n_recs_out++;
        if (expected_recs.size() == 0) begin
          $display("%0t: unexpected record, expected none, actual kind %0d",
                   $time, out_if.record_kind);
          n_errors++;
        end else begin
          exp_r = expected_recs.pop_front();
          check_field("record_kind", exp_r.kind, out_if.record_kind);
          check_field("hour", exp_r.hour, out_if.hour);
          check_field("minute", exp_r.minute, out_if.minute);
          check_field("second", exp_r.second, out_if.second);
          check_field("sub_second", exp_r.sub_second, out_if.sub_second);
          check_field("day", exp_r.day, out_if.day);
          check_field("month", exp_r.month, out_if.month);
          check_field("year", exp_r.year, out_if.year);
          check_field("latitude", exp_r.latitude, out_if.latitude);
          check_field("lat_south", exp_r.lat_south, out_if.lat_south);
          check_field("longitude", exp_r.longitude, out_if.longitude);
          check_field("lon_west", exp_r.lon_west, out_if.lon_west);
        end
      end
      if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: watchdog, no beat for %0d cycles", $time, idle_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  task test_directed();
    // full sentence closed by the ninth comma, trailing bytes ignored until last
    send_text("123519.123,A,4807.03812,N,01131.00049,E,022.4,084.4,230394,", 0);
    send_text("W,*6A", 1);
    // south/west, sentence closed by the ninth comma, trailing star ignored until last
    send_text("000000.000,V,9959.99999,S,17959.99999,W,,,991231,*", 0);
    send_beat(8'h00, 1);
    // short time, empty fields, zero latitude: no position
    send_text("1235.1,,0000.00000,N,00100.0,E,,,010100,", 1);
    // saturated minutes, truncated fraction, second point, odd letters,
    // non-digits in fixed places, open field discarded at last byte
    send_text("9a9999.99999999,A,99999.9999999,X,999999.99.9,W,,,ab12c4", 0);
    send_text(",x,123", 1);
    send_text("12345.9999999.,Q,01230.1234,E,0123456.78,w,1,2,", 0);
    send_beat(8'hFF, 1);
    // overlong time field saturates the character count
    send_text({digits(6), ".", digits(63), ",A,0100.5,N,00200.5,W", ",*"}, 1);
    send_beat(ChStar, 1);
  endtask

  task test_random(input int n_beats);
    int stop_at;
    stop_at = n_beats_in + n_beats;
    while (n_beats_in < stop_at) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 12)) send_beat(8'($urandom_range(255)), $urandom_range(7) == 0);
        send_beat(8'($urandom_range(255)), 1);
      end else begin
        send_text(random_sentence(), 1);
      end
    end
  endtask

  task test_backpressure();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_request = 400;
    repeat (4) send_text(random_sentence(), 1);
  endtask

  task wait_drained();
    in_if.valid <= 1'b0;
    while (expected_recs.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.in_byte = '0;
    in_if.last_byte = 1'b0;
    out_if.ready = 1'b0;
    clear_sentence();
    sent_over = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    src_idle_pct = 19;
    snk_idle_pct = 83;
    test_random(220);
    src_idle_pct = 83;
    snk_idle_pct = 19;
    test_random(220);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random(220);
    test_backpressure();
    wait_drained();

    $display("Sent %0d bytes of directed and random RMC sentences, checked %0d records",
             n_beats_in, n_recs_out);
    $display("under light, heavy and no stalls on each side plus one long output hold-off.");
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
